>>> design/csp_seq_pkg.sv
`default_nettype none

package csp_seq_pkg;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 31;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEP_COUNTS     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LIMIT_COUNTS    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DWELL_PERIODS   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RAMP_PERIODS    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WARN_THRESHOLD  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLEAR_THRESHOLD = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EDGE_POLICY     = 3'd6;

   // control word values
   localparam logic [15:0] CW_SHUTDOWN      = 16'h0006;
   localparam logic [15:0] CW_SWITCH_ON     = 16'h0007;
   localparam logic [15:0] CW_ENABLE_OP     = 16'h000F;
   localparam logic [15:0] CW_FAULT_RESET   = 16'h0080;
   localparam logic [15:0] CW_NEW_SETPOINT  = 16'h0010;

   // status word decode
   localparam logic [15:0] SW_STATE_MASK    = 16'h006F;
   localparam logic [15:0] SW_READY         = 16'h0021;
   localparam logic [15:0] SW_SWITCHED_ON   = 16'h0023;
   localparam logic [15:0] SW_OP_ENABLED    = 16'h0027;
   localparam logic [15:0] SW_FAULT         = 16'h0008;
   localparam logic [15:0] SW_ON_DISABLED   = 16'h0040;

   // sequence phases
   localparam logic [1:0] PH_SHUTDOWN  = 2'd0;
   localparam logic [1:0] PH_SWITCH_ON = 2'd1;
   localparam logic [1:0] PH_ENABLING  = 2'd2;
   localparam logic [1:0] PH_RUNNING   = 2'd3;

   // sweep direction
   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_BACK = 2'd3;

   typedef struct packed {
      logic capture;    // latch the accepted item
      logic prep;       // register ramp fraction operands
      logic div_start;  // launch the ramp step division
      logic commit;     // update state and result registers
   } csp_seq_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_busy;
   } csp_seq_sts_type;

endpackage

`default_nettype wire

>>> design/csp_seq_if.sv
`default_nettype none

interface csp_seq_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        drive_status;
   logic signed [31:0] actual_position;
   logic signed [31:0] tracking_error;

   modport source (output valid, drive_status, actual_position, tracking_error,
                   input ready);
   modport sink   (input valid, drive_status, actual_position, tracking_error,
                   output ready);
endinterface

interface csp_seq_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        drive_command;
   logic signed [31:0] position_setpoint;
   logic               error_warning;
   logic [1:0]         sequence_phase;

   modport source (output valid, drive_command, position_setpoint, error_warning,
                   sequence_phase, input ready);
   modport sink   (input valid, drive_command, position_setpoint, error_warning,
                   sequence_phase, output ready);
endinterface

`default_nettype wire

>>> design/csp_seq_div.sv
`default_nettype none

module csp_seq_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   localparam logic [5:0] DIV_STEPS = 6'd32;

   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] rem_sh;
   logic [16:0] rem_diff;
   logic        rem_ge;

   // restoring division, one quotient bit per cycle
   assign rem_sh   = {rem_ff, quo_ff[31]};
   assign rem_ge   = rem_sh >= {1'b0, dvs_ff};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = DIV_STEPS;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 6'd1;
         if (rem_ge) begin
            rem_in = rem_diff[15:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = cnt_ff != '0;
   // quotient never exceeds the step size, so 16 bits suffice
   assign quotient = quo_ff[15:0];

endmodule

`default_nettype wire

>>> design/csp_seq_ctrl.sv
`default_nettype none

module csp_seq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  csp_seq_pkg::csp_seq_sts_type sts,
   output csp_seq_pkg::csp_seq_cmd_type cmd
);
   import csp_seq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       slot_free;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = sts.need_div ? S_MUL : S_FINISH;
         end
         S_MUL: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

>>> design/csp_seq_dp.sv
`default_nettype none

module csp_seq_dp #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_wr_en,
   input  logic [csp_seq_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [csp_seq_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  csp_seq_pkg::csp_seq_cmd_type               cmd,
   output csp_seq_pkg::csp_seq_sts_type               sts,
   input  logic [15:0]                                drive_status,
   input  logic signed [31:0]                         actual_position,
   input  logic signed [31:0]                         tracking_error,
   output logic [15:0]                                drive_command,
   output logic signed [31:0]                         position_setpoint,
   output logic                                       error_warning,
   output logic [1:0]                                 sequence_phase
);
   import csp_seq_pkg::*;

   localparam logic [32:0] CNT_MAX = (33'd1 << COUNTER_WIDTH) - 33'd1;

   function automatic logic [COUNTER_WIDTH-1:0] cnt_load(input logic [15:0] v);
      logic [32:0] v_ext;
      v_ext = {17'b0, v};
      if (v_ext > CNT_MAX) begin
         return CNT_MAX[COUNTER_WIDTH-1:0];
      end
      return v_ext[COUNTER_WIDTH-1:0];
   endfunction

   // configuration
   logic [15:0] step_ff, dwell_ff, ramp_ff;
   logic [29:0] limit_ff;
   logic [30:0] warn_ff, clear_ff;
   logic        policy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= 16'd300;
         limit_ff  <= 30'd200000;
         dwell_ff  <= 16'd500;
         ramp_ff   <= 16'd300;
         warn_ff   <= 31'd16000;
         clear_ff  <= 31'd8000;
         policy_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_STEP_COUNTS:     step_ff   <= csr_wdata[15:0];
            REG_LIMIT_COUNTS:    limit_ff  <= csr_wdata[29:0];
            REG_DWELL_PERIODS:   dwell_ff  <= csr_wdata[15:0];
            REG_RAMP_PERIODS:    ramp_ff   <= csr_wdata[15:0];
            REG_WARN_THRESHOLD:  warn_ff   <= csr_wdata[30:0];
            REG_CLEAR_THRESHOLD: clear_ff  <= csr_wdata[30:0];
            REG_EDGE_POLICY:     policy_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // captured item
   logic [15:0]        sw_ff;
   logic signed [31:0] act_ff, err_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sw_ff  <= drive_status;
         act_ff <= actual_position;
         err_ff <= tracking_error;
      end
   end

   // sequencer state, doubles as the result register
   logic [1:0]               phase_ff, phase_in;
   logic                     release_ff, release_in;
   logic signed [31:0]       target_ff, target_in;
   logic [15:0]              control_ff, control_in;
   logic [1:0]               dir_ff, dir_in;
   logic                     last_dir_ff, last_dir_in;
   logic [COUNTER_WIDTH-1:0] dwell_left_ff, dwell_left_in;
   logic [COUNTER_WIDTH-1:0] ramp_left_ff, ramp_left_in;
   logic                     warn_latch_ff, warn_latch_in;
   logic                     toggle_ff, toggle_in;

   logic moving;
   assign moving = (dir_ff == DIR_FWD) || (dir_ff == DIR_BACK);

   assign sts.need_div = (sw_ff != '0) && ((sw_ff & SW_FAULT) == '0)
                         && ((sw_ff & SW_ON_DISABLED) == '0)
                         && (phase_ff == PH_RUNNING) && moving
                         && (ramp_left_ff != '0);

   // ramp fraction operands
   logic [31:0] total_ext, rl_ext, used_ext;
   logic [15:0] total_nz;
   logic [15:0] used_ff, total_ff;

   always_comb begin
      total_ext = 32'(cnt_load(ramp_ff));
      total_nz  = (total_ext[15:0] == '0) ? 16'd1 : total_ext[15:0];
      rl_ext    = 32'(ramp_left_ff);
      if (rl_ext >= {16'b0, total_nz}) begin
         used_ext = 32'd1;
      end else begin
         used_ext = {16'b0, total_nz} - rl_ext + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         used_ff  <= used_ext[15:0];
         total_ff <= total_nz;
      end
   end

   logic [31:0] product;
   logic [15:0] quotient;
   logic        div_busy;

   assign product = {16'b0, step_ff} * {16'b0, used_ff};

   csp_seq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (product),
      .divisor  (total_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign sts.div_busy = div_busy;

   // next state
   logic [15:0]        st;
   logic [15:0]        mag;
   logic signed [33:0] pos, lim;
   logic [31:0]        err_abs;

   always_comb begin
      phase_in      = phase_ff;
      release_in    = release_ff;
      target_in     = target_ff;
      control_in    = control_ff;
      dir_in        = dir_ff;
      last_dir_in   = last_dir_ff;
      dwell_left_in = dwell_left_ff;
      ramp_left_in  = ramp_left_ff;
      warn_latch_in = warn_latch_ff;
      toggle_in     = toggle_ff;
      st            = sw_ff & SW_STATE_MASK;
      mag           = step_ff;
      lim           = {4'b0, limit_ff};
      pos           = '0;
      err_abs       = err_ff[31] ? (~err_ff + 32'd1) : err_ff;

      if (sw_ff == '0) begin
         // hold
      end else if ((sw_ff & SW_FAULT) != '0) begin
         control_in = release_ff ? CW_SHUTDOWN : CW_FAULT_RESET;
         release_in = !release_ff;
      end else if ((sw_ff & SW_ON_DISABLED) != '0) begin
         phase_in   = PH_SHUTDOWN;
         control_in = CW_SHUTDOWN;
      end else if (phase_ff == PH_SHUTDOWN) begin
         control_in = CW_SHUTDOWN;
         if (st == SW_READY) phase_in = PH_SWITCH_ON;
      end else if (phase_ff == PH_SWITCH_ON) begin
         control_in = CW_SWITCH_ON;
         if (st == SW_SWITCHED_ON) phase_in = PH_ENABLING;
      end else if (phase_ff == PH_ENABLING) begin
         target_in  = act_ff;
         control_in = CW_ENABLE_OP;
         if (st == SW_OP_ENABLED) begin
            phase_in     = PH_RUNNING;
            ramp_left_in = cnt_load(ramp_ff);
         end
      end else begin
         if (!moving) begin
            // dwell at a limit, then reverse
            if (dwell_left_ff != '0) dwell_left_in = dwell_left_ff - COUNTER_WIDTH'(1);
            if (dwell_left_in == '0) begin
               ramp_left_in = cnt_load(ramp_ff);
               dir_in       = last_dir_ff ? DIR_FWD : DIR_BACK;
            end
         end else begin
            if (ramp_left_ff != '0) begin
               mag          = (quotient == '0) ? 16'd1 : quotient;
               ramp_left_in = ramp_left_ff - COUNTER_WIDTH'(1);
            end
            if (dir_ff == DIR_FWD) begin
               pos = 34'(target_ff) + $signed({18'b0, mag});
            end else begin
               pos = 34'(target_ff) - $signed({18'b0, mag});
            end
            if (pos > lim) begin
               pos           = lim;
               dwell_left_in = cnt_load(dwell_ff);
               dir_in        = DIR_STOP;
               last_dir_in   = 1'b0;
            end
            if (pos < -lim) begin
               pos           = -lim;
               dwell_left_in = cnt_load(dwell_ff);
               dir_in        = DIR_STOP;
               last_dir_in   = 1'b1;
            end
            target_in = pos[31:0];
         end

         if (!policy_ff || (target_in != target_ff)) toggle_in = !toggle_ff;
         control_in = toggle_in ? (CW_ENABLE_OP | CW_NEW_SETPOINT) : CW_ENABLE_OP;

         if (!warn_latch_ff && (err_abs > {1'b0, warn_ff})) begin
            warn_latch_in = 1'b1;
         end else if (warn_latch_ff && (err_abs < {1'b0, clear_ff})) begin
            warn_latch_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SHUTDOWN;
         release_ff    <= 1'b0;
         target_ff     <= '0;
         control_ff    <= '0;
         dir_ff        <= DIR_FWD;
         last_dir_ff   <= 1'b0;
         dwell_left_ff <= '0;
         ramp_left_ff  <= '0;
         warn_latch_ff <= 1'b0;
         toggle_ff     <= 1'b0;
      end else if (cmd.commit) begin
         phase_ff      <= phase_in;
         release_ff    <= release_in;
         target_ff     <= target_in;
         control_ff    <= control_in;
         dir_ff        <= dir_in;
         last_dir_ff   <= last_dir_in;
         dwell_left_ff <= dwell_left_in;
         ramp_left_ff  <= ramp_left_in;
         warn_latch_ff <= warn_latch_in;
         toggle_ff     <= toggle_in;
      end
   end

   assign drive_command     = control_ff;
   assign position_setpoint = target_ff;
   assign error_warning     = warn_latch_ff;
   assign sequence_phase    = phase_ff;

endmodule

`default_nettype wire

>>> design/cia402_csp_setpoint_sequencer_top.sv
// CiA-402 cyclic position set-point sequencer.
// req_bus carries one transfer per control period: drive status word,
// actual position and following error. rsp_bus returns exactly one transfer
// per request: control word, target position, warning flag and phase.
// csr_* writes one configuration register per cycle (index 0..6); the
// user must write only while the block is idle, as the block does not
// enforce it; indexes beyond the list are ignored. A request whose period
// needs no ramp scaling is captured, prepared and then committed, which
// raises rsp_valid. A ramped running period also runs the step scaling
// through a 16x16 multiply and a one-bit-per-cycle 32-step divider. One
// request is worked on at a time; the next request is taken in the cycle
// after the previous one is committed.
// The result registers are the sequencer state itself; a new request is
// accepted while a result still waits, and its commit waits until the held
// result is taken, so a stalled receiver only stalls the commit.
// Reset (synchronous) restores all register defaults, phase shutdown,
// control word and target zero, and drops rsp_valid.
`default_nettype none

module cia402_csp_setpoint_sequencer_top #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   csp_seq_req_if.sink                             req_bus,
   csp_seq_rsp_if.source                           rsp_bus,
   input  logic                                    csr_wr_en,
   input  logic [csp_seq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [csp_seq_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import csp_seq_pkg::*;

   csp_seq_cmd_type cmd;
   csp_seq_sts_type sts;

   // sequencing of capture, scaling and commit
   csp_seq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // configuration, drive state machine, sweep generator, warning latch
   csp_seq_dp #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .sts               (sts),
      .drive_status      (req_bus.drive_status),
      .actual_position   (req_bus.actual_position),
      .tracking_error    (req_bus.tracking_error),
      .drive_command     (rsp_bus.drive_command),
      .position_setpoint (rsp_bus.position_setpoint),
      .error_warning     (rsp_bus.error_warning),
      .sequence_phase    (rsp_bus.sequence_phase)
   );

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

// Checks the CSP set-point sequencer against a cycle-free model of its
// per-period behavior. Periods are queued by the stimulus process, fed to
// the request channel by a clocked driver, and every response transfer is
// compared with the setpoint predicted when the matching request was taken.
module tb;
   import csp_seq_pkg::*;

   typedef struct {
      logic [15:0]        status;
      logic signed [31:0] position;
      logic signed [31:0] ferr;
   } drive_period_type;

   typedef struct {
      logic [15:0]        cw;
      logic signed [31:0] target;
      logic               warn;
      logic [1:0]         phase;
   } setpoint_type;

   logic clock;
   logic reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   csp_seq_req_if req_bus ();
   csp_seq_rsp_if rsp_bus ();

   cia402_csp_setpoint_sequencer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   drive_period_type pending_periods[$];
   setpoint_type     expected_setpoints[$];
   drive_period_type cur_period;
   int unsigned      periods_added;
   int unsigned      error_count;
   bit               steady;     // when set, neither side inserts bubbles

   // ------------------------------------------------------------------
   // Model state: configuration copy and sequencer registers.
   // ------------------------------------------------------------------
   logic [15:0]        cfg_step;
   logic [29:0]        cfg_limit;
   logic [15:0]        cfg_dwell;
   logic [15:0]        cfg_ramp;
   logic [30:0]        cfg_warn;
   logic [30:0]        cfg_clear;
   logic               cfg_policy;

   logic [1:0]         m_phase;
   logic               m_release;
   logic signed [31:0] m_target;
   logic [15:0]        m_cw;
   logic [1:0]         m_dir;
   logic               m_last_back;  // last sweep before the dwell ran backward
   logic [15:0]        m_dwell;
   logic [15:0]        m_ramp;
   logic               m_warn;
   logic               m_toggle;

   function automatic void model_reset();
      cfg_step    = 16'd300;
      cfg_limit   = 30'd200000;
      cfg_dwell   = 16'd500;
      cfg_ramp    = 16'd300;
      cfg_warn    = 31'd16000;
      cfg_clear   = 31'd8000;
      cfg_policy  = 1'b1;
      m_phase     = PH_SHUTDOWN;
      m_release   = 1'b0;
      m_target    = '0;
      m_cw        = '0;
      m_dir       = DIR_FWD;
      m_last_back = 1'b0;
      m_dwell     = '0;
      m_ramp      = '0;
      m_warn      = 1'b0;
      m_toggle    = 1'b0;
   endfunction

   // One control period. Counters are 16 bits wide here, so loads from the
   // 16-bit registers never saturate.
   function automatic setpoint_type sequence_period(input drive_period_type p);
      logic [15:0]        st;
      logic signed [31:0] prev;
      longint             mag, pos, lim, total, used, e, a;
      setpoint_type       r;
      st = p.status & SW_STATE_MASK;
      if (p.status == 16'h0000) begin
         // hold everything
      end else if ((p.status & SW_FAULT) != 16'h0000) begin
         m_cw = m_release ? CW_SHUTDOWN : CW_FAULT_RESET;
         m_release = ~m_release;
      end else if ((p.status & SW_ON_DISABLED) != 16'h0000) begin
         m_phase = PH_SHUTDOWN;
         m_cw = CW_SHUTDOWN;
      end else if (m_phase == PH_SHUTDOWN) begin
         m_cw = CW_SHUTDOWN;
         if (st == SW_READY) m_phase = PH_SWITCH_ON;
      end else if (m_phase == PH_SWITCH_ON) begin
         m_cw = CW_SWITCH_ON;
         if (st == SW_SWITCHED_ON) m_phase = PH_ENABLING;
      end else if (m_phase == PH_ENABLING) begin
         // target follows the encoder until operation is enabled
         m_target = p.position;
         m_cw = CW_ENABLE_OP;
         if (st == SW_OP_ENABLED) begin
            m_phase = PH_RUNNING;
            m_ramp = cfg_ramp;
         end
      end else begin
         prev = m_target;
         if (m_dir != DIR_FWD && m_dir != DIR_BACK) begin
            // dwell at a limit, then reverse with a fresh ramp
            if (m_dwell != 16'd0) m_dwell = m_dwell - 16'd1;
            if (m_dwell == 16'd0) begin
               m_ramp = cfg_ramp;
               m_dir = m_last_back ? DIR_FWD : DIR_BACK;
            end
         end else begin
            mag = longint'(cfg_step);
            lim = longint'(cfg_limit);
            if (m_ramp != 16'd0) begin
               total = longint'(cfg_ramp);
               if (total == 0) total = 1;
               // ramp fraction floors at 1/total if the register was lowered
               used = (longint'(m_ramp) >= total) ? 1 : total - longint'(m_ramp) + 1;
               mag = (mag * used) / total;
               if (mag == 0) mag = 1;
               m_ramp = m_ramp - 16'd1;
            end
            pos = longint'(m_target) + ((m_dir == DIR_FWD) ? mag : -mag);
            if (pos > lim) begin
               pos = lim;
               m_dwell = cfg_dwell;
               m_dir = DIR_STOP;
               m_last_back = 1'b0;
            end
            if (pos < -lim) begin
               pos = -lim;
               m_dwell = cfg_dwell;
               m_dir = DIR_STOP;
               m_last_back = 1'b1;
            end
            m_target = pos[31:0];
         end
         if (!cfg_policy || m_target != prev) m_toggle = ~m_toggle;
         m_cw = CW_ENABLE_OP | (m_toggle ? CW_NEW_SETPOINT : 16'h0000);
         // following error warning, set above warn and cleared below clear
         e = longint'(p.ferr);
         a = (e < 0) ? -e : e;
         if (!m_warn && a > longint'(cfg_warn)) m_warn = 1'b1;
         else if (m_warn && a < longint'(cfg_clear)) m_warn = 1'b0;
      end
      r.cw     = m_cw;
      r.target = m_target;
      r.warn   = m_warn;
      r.phase  = m_phase;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Clock, bubbles, driver and monitor.
   // ------------------------------------------------------------------
   always #6 clock = ~clock;

   function automatic bit take_gap();
      return !steady && ($urandom_range(99) < 11);
   endfunction

   // Request driver: on a transfer, predict the response; then present the
   // next queued period or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_setpoints.push_back(sequence_period(cur_period));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_periods.size() != 0 && !take_gap()) begin
               cur_period = pending_periods.pop_front();
               req_bus.valid           <= 1'b1;
               req_bus.drive_status    <= cur_period.status;
               req_bus.actual_position <= cur_period.position;
               req_bus.tracking_error  <= cur_period.ferr;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure.
   always @(posedge clock) begin
      setpoint_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_setpoints.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected response transfer: cw %h target %0d warn %0b phase %0d",
                           rsp_bus.drive_command, rsp_bus.position_setpoint,
                           rsp_bus.error_warning, rsp_bus.sequence_phase);
            end else begin
               want = expected_setpoints.pop_front();
               if (rsp_bus.drive_command !== want.cw
                   || rsp_bus.position_setpoint !== want.target
                   || rsp_bus.error_warning !== want.warn
                   || rsp_bus.sequence_phase !== want.phase) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"setpoint mismatch (exp/got): cw %h/%h target %0d/%0d",
                               " warn %0b/%0b phase %0d/%0d"},
                              want.cw, rsp_bus.drive_command,
                              want.target, rsp_bus.position_setpoint,
                              want.warn, rsp_bus.error_warning,
                              want.phase, rsp_bus.sequence_phase);
               end
            end
         end
         rsp_bus.ready <= !take_gap();
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic void add_period(input logic [15:0] status,
                                      input logic signed [31:0] position,
                                      input logic signed [31:0] ferr);
      drive_period_type p;
      p.status   = status;
      p.position = position;
      p.ferr     = ferr;
      pending_periods.push_back(p);
      periods_added++;
   endfunction

   // Status bits outside the state mask (bit 4, bits 7..15).
   function automatic logic [15:0] spare_bits();
      return 16'($urandom) & ~SW_STATE_MASK;
   endfunction

   // Mostly near the current limits, sometimes anywhere or at the extremes.
   function automatic logic signed [31:0] rand_position();
      longint span, v;
      span = longint'(cfg_limit) + 4;
      case ($urandom_range(7))
         0: return $urandom;
         1: return 32'sh8000_0000;
         2: return 32'sh7FFF_FFFF;
         default: begin
            v = longint'($urandom_range(32'(2 * span))) - span;
            return v[31:0];
         end
      endcase
   endfunction

   // Concentrates around both thresholds so the hysteresis gets worked.
   function automatic logic signed [31:0] rand_error();
      longint v;
      case ($urandom_range(9))
         0: return $urandom;
         1: return 32'sh8000_0000;
         2: return 32'sh7FFF_FFFF;
         3: v = longint'($urandom_range(32'(cfg_warn)));
         default: begin
            v = ($urandom_range(1) ? longint'(cfg_warn) : longint'(cfg_clear))
                + longint'($urandom_range(4)) - 2;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < 0) v = 0;
         end
      endcase
      if ($urandom_range(1)) v = -v;
      return v[31:0];
   endfunction

   // Well-formed enable sequence followed by running periods, with a little
   // noise (hold, fault, switch-on disabled, arbitrary words) mixed in.
   task automatic add_session(input int unsigned run_len);
      int unsigned roll;
      logic [15:0] sw;
      if ($urandom_range(1))
         add_period((16'($urandom) & ~SW_FAULT) | SW_ON_DISABLED, rand_position(), rand_error());
      add_period(SW_READY | spare_bits(), rand_position(), rand_error());
      add_period(SW_SWITCHED_ON | spare_bits(), rand_position(), rand_error());
      repeat ($urandom_range(2))
         add_period(SW_SWITCHED_ON | spare_bits(), rand_position(), rand_error());
      add_period(SW_OP_ENABLED | spare_bits(), rand_position(), rand_error());
      repeat (run_len) begin
         roll = $urandom_range(99);
         if (roll < 4)       sw = 16'h0000;
         else if (roll < 8)  sw = 16'($urandom) | SW_FAULT;
         else if (roll < 10) sw = (16'($urandom) & ~SW_FAULT) | SW_ON_DISABLED;
         else if (roll < 13) sw = 16'($urandom);
         else if (roll < 20) sw = (16'($urandom) & ~(SW_FAULT | SW_ON_DISABLED)) | 16'h0001;
         else                sw = SW_OP_ENABLED | spare_bits();
         add_period(sw, rand_position(), rand_error());
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_STEP_COUNTS:     cfg_step   = value[15:0];
         REG_LIMIT_COUNTS:    cfg_limit  = value[29:0];
         REG_DWELL_PERIODS:   cfg_dwell  = value[15:0];
         REG_RAMP_PERIODS:    cfg_ramp   = value[15:0];
         REG_WARN_THRESHOLD:  cfg_warn   = value[30:0];
         REG_CLEAR_THRESHOLD: cfg_clear  = value[30:0];
         REG_EDGE_POLICY:     cfg_policy = value[0];
         default: ;
      endcase
   endtask

   // Everything accepted and answered, plus the block's worst-case latency.
   task automatic wait_idle();
      while (pending_periods.size() != 0 || req_bus.valid || expected_setpoints.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned step, input int unsigned limit,
                            input int unsigned dwell, input int unsigned ramp,
                            input int unsigned warn, input int unsigned clr,
                            input int unsigned policy, input int unsigned count);
      int unsigned first;
      write_reg(REG_STEP_COUNTS, CSR_DATA_WIDTH'(step));
      write_reg(REG_LIMIT_COUNTS, CSR_DATA_WIDTH'(limit));
      write_reg(REG_DWELL_PERIODS, CSR_DATA_WIDTH'(dwell));
      write_reg(REG_RAMP_PERIODS, CSR_DATA_WIDTH'(ramp));
      write_reg(REG_WARN_THRESHOLD, CSR_DATA_WIDTH'(warn));
      write_reg(REG_CLEAR_THRESHOLD, CSR_DATA_WIDTH'(clr));
      write_reg(REG_EDGE_POLICY, CSR_DATA_WIDTH'(policy));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      first = periods_added;
      while (periods_added - first < count) add_session($urandom_range(3, 40));
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_bus.valid           = 1'b0;
      req_bus.drive_status    = '0;
      req_bus.actual_position = '0;
      req_bus.tracking_error  = '0;
      rsp_bus.ready = 1'b0;
      steady        = 1'b0;
      periods_added = 0;
      error_count   = 0;
      model_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed walk on reset defaults: hold, fault alternation, the
      // switch-on-disabled fallback, the enable steps with alignment to the
      // encoder extremes, and a limit clamp straight out of enable.
      add_period(16'h0000, 32'sd5, 32'sd0);
      add_period(SW_READY, 32'sd0, 32'sd0);
      add_period(SW_FAULT, 32'sd0, 32'sd0);
      add_period(SW_FAULT, 32'sd0, 32'sd0);
      add_period(16'hFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      add_period(SW_ON_DISABLED, 32'sd0, 32'sd0);
      add_period(SW_READY, 32'sd0, 32'sd0);
      add_period(SW_SWITCHED_ON, 32'sd0, 32'sd0);
      add_period(SW_SWITCHED_ON, 32'sh8000_0000, 32'sd0);
      add_period(SW_OP_ENABLED, 32'sh7FFF_FFFF, 32'sd0);
      add_period(SW_OP_ENABLED, 32'sd0, 32'sh8000_0000);   // clamp to limit, warn sets
      add_period(SW_OP_ENABLED, 32'sd0, 32'sd0);           // dwell, warn clears
      add_period(16'h0000, 32'sd0, 32'sd16001);
      add_period(16'hFFB7, 32'sd0, 32'sd16001);            // every non-decoded bit high
      add_period(SW_OP_ENABLED, 32'sd0, -32'sd16001);
      add_period(SW_OP_ENABLED, 32'sd0, 32'sd8000);
      add_period(SW_OP_ENABLED, 32'sd0, 32'sd7999);
      wait_idle();

      // Short sweep so the limits and dwells come around often.
      run_phase(300, 2000, 3, 5, 1000, 500, 1, 150);
      // Extremes, ramp off, zero dwell, toggle every period; no bubbles.
      steady = 1'b1;
      run_phase(65535, 1073741823, 0, 0, 0, 0, 0, 200);
      steady = 1'b0;
      // Zero step and zero limit: ramp forces a one-count step into a clamp.
      run_phase(0, 0, 1, 65535, 2147483647, 2147483647, 1, 100);
      run_phase(1000, 50000, 2, 60, 3000, 3000, 0, 150);
      // Ramp register shortened while a long ramp may still be pending.
      run_phase(7, 100, 2, 2, 20, 40, 1, 100);
      // Longest dwell: the sweep parks at the first limit it reaches.
      run_phase(500, 3000, 65535, 0, 100, 50, 0, 40);
      repeat (5)
         run_phase($urandom_range(2000), $urandom_range(20000), $urandom_range(8),
                   $urandom_range(30), $urandom_range(40000), $urandom_range(40000),
                   $urandom_range(1), 50);

      if (expected_setpoints.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
design/csp_seq_pkg.sv
design/csp_seq_if.sv
design/csp_seq_div.sv
design/csp_seq_ctrl.sv
design/csp_seq_dp.sv
design/cia402_csp_setpoint_sequencer_top.sv
verif/tb.sv
